>>> rtl/mccr_pkg.sv
// shared types and constants for the multi-circle collision region block
package mccr_pkg;

	// default depth of the circle tables
	localparam int MAX_CIRCLES_DEF = 16;

	// register and stream word widths
	localparam int COUNT_W   = 5;
	localparam int S_TDATA_W = 120;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 8;

	// table word widths
	localparam int BASE_W  = 47;
	localparam int WORLD_W = 48;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_XFORM  = 2'd1,
		OP_CQUERY = 2'd2,
		OP_PQUERY = 2'd3
	} op_t;

	// one request to the shared multiplier
	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

>>> rtl/multi_circle_collision_region_core.sv
// top level of the multi-circle collision region block
//
// Keeps a table of base circles and a transformed (world) copy and answers
// overlap queries against the world table. Words come in on the s_ side and
// one result word goes out on the m_ side for every input word. Everything
// runs through one shared 33x18 signed multiplier under a small sequencer,
// one item at a time: s_tready is high only while the block is idle. A load
// goes straight to the done step. A transform takes each active circle
// through a table read, seven products and a write-back step, then the done
// step. A circle or point query takes each circle through a read, a
// difference step, three products and a compare, then the done step; it
// stops at the first hit. With a count of zero every item goes straight to
// the done step. The block goes back to idle as the result word turns valid.
// The result sits in an output register, so a new word is taken while the
// last result still waits on m_tready; a finished word holds in the done
// step until that register frees. The world table reads as zero until a
// transform writes an entry; base entries read by a transform must have been
// loaded first. The user must write circle_count only while the block is idle
// (the block does not enforce it); counts above MAX_CIRCLES act as MAX_CIRCLES.
module multi_circle_collision_region_core #(
	parameter int MAX_CIRCLES = mccr_pkg::MAX_CIRCLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config register circle_count
	input  logic                            cfg_we,
	input  logic [mccr_pkg::COUNT_W-1:0]    cfg_wdata,
	// input words
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// entry_index, pos_x, pos_y, radius, cos_val, sin_val, scale_x, scale_y, zero pad
	input  logic [mccr_pkg::S_TDATA_W-1:0]  s_tdata,
	// opcode
	input  logic [mccr_pkg::S_TUSER_W-1:0]  s_tuser,
	// result words
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// hit, hit_index, zero pad
	output logic [mccr_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int CNT_W = $clog2(MAX_CIRCLES + 1);
	localparam int IDX_W = MAX_CIRCLES > 1 ? $clog2(MAX_CIRCLES) : 1;
	localparam int NW    = CNT_W > mccr_pkg::COUNT_W ? CNT_W : mccr_pkg::COUNT_W;
	localparam logic signed [47:0] ROUND = 48'sd33554432;

	// sequencer states: T* walk the transform, Q* walk a query
	typedef enum logic [17:0] {
		S_IDLE = 18'b000000000000000001,
		S_T_RD = 18'b000000000000000010,
		S_T0   = 18'b000000000000000100,
		S_T1   = 18'b000000000000001000,
		S_T2   = 18'b000000000000010000,
		S_T3   = 18'b000000000000100000,
		S_T4   = 18'b000000000001000000,
		S_T5   = 18'b000000000010000000,
		S_T6   = 18'b000000000100000000,
		S_T7   = 18'b000000001000000000,
		S_Q_RD = 18'b000000010000000000,
		S_Q0   = 18'b000000100000000000,
		S_Q1   = 18'b000001000000000000,
		S_Q2   = 18'b000010000000000000,
		S_Q3   = 18'b000100000000000000,
		S_Q4   = 18'b001000000000000000,
		S_DONE = 18'b010000000000000000,
		S_SPARE = 18'b100000000000000000
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
		if (v > 23'sd32767) begin
			return 16'sh7fff;
		end else if (v < -23'sd32768) begin
			return -16'sd32768;
		end else begin
			return v[15:0];
		end
	endfunction

	// control state
	state_t               state_q;
	logic [mccr_pkg::COUNT_W-1:0] count_q;
	logic [MAX_CIRCLES-1:0] wvalid_q;
	logic                 m_tvalid_q;

	// item and datapath registers
	mccr_pkg::op_t        op_q;
	logic signed [15:0]   px_q, py_q, cs_q, sn_q;
	logic [14:0]          rad_q;
	logic [15:0]          scx_q, scy_q, smax_q;
	logic [CNT_W-1:0]     n_q, i_q;
	logic signed [31:0]   sx_q, sy_q;
	logic signed [47:0]   acc_q, rxy_q;
	logic signed [15:0]   wx_q;
	logic signed [16:0]   dx_q, dy_q;
	logic [16:0]          lim_q;
	logic                 hit_q;
	logic [3:0]           res_idx_q;
	logic [mccr_pkg::M_TDATA_W-1:0] m_tdata_q;

	// input word fields
	mccr_pkg::op_t        in_op;
	logic [3:0]           in_idx;
	logic signed [15:0]   in_x, in_y, in_cs, in_sn;
	logic [14:0]          in_rad;
	logic [15:0]          in_scx, in_scy;

	assign in_op  = mccr_pkg::op_t'(s_tuser[1:0]);
	assign in_idx = s_tdata[3:0];
	assign in_x   = s_tdata[19:4];
	assign in_y   = s_tdata[35:20];
	assign in_rad = s_tdata[50:36];
	assign in_cs  = s_tdata[66:51];
	assign in_sn  = s_tdata[82:67];
	assign in_scx = s_tdata[98:83];
	assign in_scy = s_tdata[114:99];

	logic s_accept;
	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// active circle count, clipped to the table depth
	logic [NW-1:0] cnt_ext, n_sel;
	assign cnt_ext = NW'(count_q);
	assign n_sel   = (cnt_ext > NW'(MAX_CIRCLES)) ? NW'(MAX_CIRCLES) : cnt_ext;

	logic [IDX_W-1:0] i_idx;
	logic [CNT_W-1:0] i_next;
	logic             last_circle;
	assign i_idx       = i_q[IDX_W-1:0];
	assign i_next      = i_q + CNT_W'(1);
	assign last_circle = (i_next == n_q);

	// base table: {x, y, r}
	logic                        base_we;
	logic [mccr_pkg::BASE_W-1:0] base_rdata;
	logic signed [15:0]          bx, by;
	logic [14:0]                 br;

	assign base_we = s_accept && (in_op == mccr_pkg::OP_LOAD)
		&& (9'(in_idx) < 9'(MAX_CIRCLES));

	mccr_ram #(
		.W     (mccr_pkg::BASE_W),
		.DEPTH (MAX_CIRCLES)
	) u_base_ram (
		.clk   (clk),
		.we    (base_we),
		.waddr (IDX_W'(in_idx)),
		.wdata ({in_x, in_y, in_rad}),
		.re    (state_q == S_T_RD),
		.raddr (i_idx),
		.rdata (base_rdata)
	);

	assign bx = base_rdata[46:31];
	assign by = base_rdata[30:15];
	assign br = base_rdata[14:0];

	// shared multiplier
	mccr_pkg::mul_req_t             mreq;
	logic signed [mccr_pkg::MUL_P_W-1:0] p;
	logic signed [47:0]             pt;

	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_T0: begin
				mreq = '{en: 1'b1, a: {{17{bx[15]}}, bx}, b: {2'b00, scx_q}};
			end
			S_T1: begin
				mreq = '{en: 1'b1, a: {{17{by[15]}}, by}, b: {2'b00, scy_q}};
			end
			S_T2: begin
				mreq = '{en: 1'b1, a: {sx_q[31], sx_q}, b: {{2{cs_q[15]}}, cs_q}};
			end
			S_T3: begin
				mreq = '{en: 1'b1, a: {sy_q[31], sy_q}, b: {{2{sn_q[15]}}, sn_q}};
			end
			S_T4: begin
				mreq = '{en: 1'b1, a: {sx_q[31], sx_q}, b: {{2{sn_q[15]}}, sn_q}};
			end
			S_T5: begin
				mreq = '{en: 1'b1, a: {sy_q[31], sy_q}, b: {{2{cs_q[15]}}, cs_q}};
			end
			S_T6: begin
				mreq = '{en: 1'b1, a: {18'b0, br}, b: {2'b00, smax_q}};
			end
			S_Q1: begin
				mreq = '{en: 1'b1, a: {{16{dx_q[16]}}, dx_q}, b: {dx_q[16], dx_q}};
			end
			S_Q2: begin
				mreq = '{en: 1'b1, a: {{16{dy_q[16]}}, dy_q}, b: {dy_q[16], dy_q}};
			end
			S_Q3: begin
				mreq = '{en: 1'b1, a: {16'b0, lim_q}, b: {1'b0, lim_q}};
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	mccr_mul u_mul (
		.clk (clk),
		.req (mreq),
		.p   (p)
	);

	assign pt = p[47:0];

	// world table: {x, y, r}, entries never written read as zero
	logic                         world_we;
	logic [mccr_pkg::WORLD_W-1:0] world_rdata, world_word;
	logic signed [15:0]           wx, wy;
	logic [15:0]                  wr;

	// rounded rotation result plus translation, shared by x and y
	logic signed [22:0] shift_sum;
	logic signed [15:0] tr_sel;
	logic [31:0]        r_round;
	logic [15:0]        r_sat;
	logic signed [15:0] wy_new;

	assign tr_sel    = (state_q == S_T7) ? py_q : px_q;
	assign shift_sum = {rxy_q[47], rxy_q[47:26]} + {{7{tr_sel[15]}}, tr_sel};
	assign r_round   = p[31:0] + 32'd2048;
	assign r_sat     = (r_round[31:28] != 4'd0) ? 16'hffff : r_round[27:12];
	assign wy_new    = sat16(shift_sum);
	assign world_we  = (state_q == S_T7);

	mccr_ram #(
		.W     (mccr_pkg::WORLD_W),
		.DEPTH (MAX_CIRCLES)
	) u_world_ram (
		.clk   (clk),
		.we    (world_we),
		.waddr (i_idx),
		.wdata ({wx_q, wy_new, r_sat}),
		.re    (state_q == S_Q_RD),
		.raddr (i_idx),
		.rdata (world_rdata)
	);

	assign world_word = wvalid_q[i_idx] ? world_rdata : '0;
	assign wx = world_word[47:32];
	assign wy = world_word[31:16];
	assign wr = world_word[15:0];

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= mccr_pkg::COUNT_W'(1);
			wvalid_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (world_we) begin
				wvalid_q[i_idx] <= 1'b1;
			end
			// output register: load a finished word or drain on handshake
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						if (in_op == mccr_pkg::OP_LOAD || n_sel == '0) begin
							state_q <= S_DONE;
						end else if (in_op == mccr_pkg::OP_XFORM) begin
							state_q <= S_T_RD;
						end else begin
							state_q <= S_Q_RD;
						end
					end
				end
				S_T_RD: state_q <= S_T0;
				S_T0:   state_q <= S_T1;
				S_T1:   state_q <= S_T2;
				S_T2:   state_q <= S_T3;
				S_T3:   state_q <= S_T4;
				S_T4:   state_q <= S_T5;
				S_T5:   state_q <= S_T6;
				S_T6:   state_q <= S_T7;
				S_T7: begin
					state_q <= last_circle ? S_DONE : S_T_RD;
				end
				S_Q_RD: state_q <= S_Q0;
				S_Q0:   state_q <= S_Q1;
				S_Q1:   state_q <= S_Q2;
				S_Q2:   state_q <= S_Q3;
				S_Q3:   state_q <= S_Q4;
				S_Q4: begin
					// stop at the first overlapping circle
					if (acc_q < pt || last_circle) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_Q_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q      <= in_op;
			px_q      <= in_x;
			py_q      <= in_y;
			rad_q     <= in_rad;
			cs_q      <= in_cs;
			sn_q      <= in_sn;
			scx_q     <= in_scx;
			scy_q     <= in_scy;
			smax_q    <= (in_scx > in_scy) ? in_scx : in_scy;
			n_q       <= n_sel[CNT_W-1:0];
			i_q       <= '0;
			hit_q     <= 1'b0;
			res_idx_q <= '0;
		end
		unique case (state_q)
			S_T1: sx_q <= p[31:0];
			S_T2: sy_q <= p[31:0];
			S_T3: acc_q <= pt + ROUND;
			S_T4: rxy_q <= acc_q - pt;
			S_T5: begin
				acc_q <= pt + ROUND;
				wx_q  <= sat16(shift_sum);
			end
			S_T6: rxy_q <= acc_q + pt;
			S_T7: i_q <= i_next;
			S_Q0: begin
				dx_q  <= {wx[15], wx} - {px_q[15], px_q};
				dy_q  <= {wy[15], wy} - {py_q[15], py_q};
				lim_q <= {1'b0, wr}
					+ ((op_q == mccr_pkg::OP_CQUERY) ? {2'b00, rad_q} : 17'd0);
			end
			S_Q2: acc_q <= pt;
			S_Q3: acc_q <= acc_q + pt;
			S_Q4: begin
				if (acc_q < pt) begin
					hit_q     <= 1'b1;
					res_idx_q <= 4'(i_q);
				end else begin
					i_q <= i_next;
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {3'b000, res_idx_q, hit_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/mccr_ram.sv
// generic single-write, single-read ram with registered read data
module mccr_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [W-1:0]                           wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0]                           rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/mccr_mul.sv
// shared signed multiplier with registered product
module mccr_mul (
	input  logic                                 clk,
	input  mccr_pkg::mul_req_t                   req,
	output logic signed [mccr_pkg::MUL_P_W-1:0]  p
);

	logic signed [mccr_pkg::MUL_A_W-1:0] a;
	logic signed [mccr_pkg::MUL_B_W-1:0] b;
	logic signed [mccr_pkg::MUL_P_W-1:0] p_q;

	assign a = req.a;
	assign b = req.b;

	always_ff @(posedge clk) begin
		if (req.en) begin
			p_q <= a * b;
		end
	end

	assign p = p_q;

endmodule

>>> rtl/mccr_chk.sv
// port checker for the multi-circle collision region block, with its bind
module mccr_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [mccr_pkg::M_TDATA_W-1:0] m_tdata
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// a miss always reports index zero
	a_miss_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
		else $error("miss with nonzero index");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a word while busy");

	// a new result comes only out of a busy cycle
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without work");

endmodule

bind multi_circle_collision_region_core mccr_chk u_mccr_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the multi-circle collision region block
module testbench;
	import mccr_pkg::*;

	localparam int NCIRC = MAX_CIRCLES_DEF;

	// one input word split into its fields
	typedef struct {
		op_t                op;
		logic [3:0]         idx;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [14:0]        rad;
		logic signed [15:0] cs;
		logic signed [15:0] sn;
		logic [15:0]        scx;
		logic [15:0]        scy;
	} region_word_t;

	// one result word split into its fields
	typedef struct {
		logic       hit;
		logic [3:0] hidx;
	} hit_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [COUNT_W-1:0]    cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// entry_index, pos_x, pos_y, radius, cos_val, sin_val, scale_x, scale_y, zero pad
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	// opcode
	logic [S_TUSER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// hit, hit_index, zero pad
	logic [M_TDATA_W-1:0]  m_tdata;

	// shadow of the block's tables and register
	logic signed [15:0] base_x  [NCIRC];
	logic signed [15:0] base_y  [NCIRC];
	logic [14:0]        base_r  [NCIRC];
	logic signed [15:0] world_x [NCIRC];
	logic signed [15:0] world_y [NCIRC];
	logic [15:0]        world_r [NCIRC];
	logic [4:0]         region_count;

	region_word_t pending_words [$];
	hit_word_t    expected_hits [$];
	region_word_t cur_word;
	hit_word_t    oldest_hit;

	logic tb_live = 1'b0;
	logic have_word = 1'b0;
	logic word_taken = 1'b0;
	logic no_gaps = 1'b0;
	logic hold_start = 1'b0;
	int   hold_left = 0;
	int   words_queued = 0;
	int   results_seen = 0;
	int   mismatches = 0;

	multi_circle_collision_region_core #(
		.MAX_CIRCLES(NCIRC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// apply one word to the shadow tables and return the hit word it gives
	function automatic hit_word_t apply_word(region_word_t w);
		hit_word_t res;
		int n;
		longint sx, sy, rx, ry, qx, qy, smax, rr, dx, dy;
		longint unsigned d2, lim;
		res.hit = 1'b0;
		res.hidx = 4'd0;
		n = (region_count > NCIRC) ? NCIRC : int'(region_count);
		case (w.op)
			OP_LOAD: begin
				base_x[w.idx] = w.px;
				base_y[w.idx] = w.py;
				base_r[w.idx] = w.rad;
			end
			OP_XFORM: begin
				smax = (w.scx > w.scy) ? longint'(w.scx) : longint'(w.scy);
				for (int i = 0; i < n; i++) begin
					sx = longint'(base_x[i]) * longint'(w.scx);
					sy = longint'(base_y[i]) * longint'(w.scy);
					rx = sx * longint'(w.cs) - sy * longint'(w.sn);
					ry = sx * longint'(w.sn) + sy * longint'(w.cs);
					// round off the q.26 fraction of the product: add half an lsb, then floor
					qx = (rx + 64'sd33554432) >>> 26;
					qy = (ry + 64'sd33554432) >>> 26;
					world_x[i] = clamp16(qx + longint'(w.px));
					world_y[i] = clamp16(qy + longint'(w.py));
					rr = (longint'(base_r[i]) * smax + 2048) >>> 12;
					world_r[i] = (rr > 65535) ? 16'hffff : rr[15:0];
				end
			end
			default: begin
				for (int i = 0; i < n; i++) begin
					dx = longint'(world_x[i]) - longint'(w.px);
					dy = longint'(world_y[i]) - longint'(w.py);
					d2 = dx * dx + dy * dy;
					lim = longint'(world_r[i]);
					if (w.op == OP_CQUERY)
						lim = lim + longint'(w.rad);
					if (d2 < lim * lim) begin
						res.hit = 1'b1;
						res.hidx = 4'(i);
						break;
					end
				end
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on result word %0d at %0t: %s got %0d want %0d",
			results_seen, $time, what, got, want);
		mismatches++;
	endtask

	// sender: a word stays offered until it is taken
	always @(negedge clk) begin
		if (tb_live) begin
			if (word_taken) begin
				have_word = 1'b0;
				word_taken = 1'b0;
			end
			if (!have_word && pending_words.size() > 0 &&
					(no_gaps || $urandom_range(99) >= 18)) begin
				cur_word = pending_words.pop_front();
				have_word = 1'b1;
			end
			s_tvalid <= have_word;
			s_tdata <= {5'd0, cur_word.scy, cur_word.scx, cur_word.sn, cur_word.cs,
				cur_word.rad, cur_word.py, cur_word.px, cur_word.idx};
			s_tuser <= cur_word.op;
		end
	end

	// accepted input word: predict its result
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expected_hits.push_back(apply_word(cur_word));
			word_taken = 1'b1;
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (tb_live) begin
			if (hold_start) begin
				hold_left = 400;
				hold_start = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_gaps || ($urandom_range(99) >= 18);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected result word, tdata", int'(m_tdata), 0);
			end else begin
				oldest_hit = expected_hits.pop_front();
				if (m_tdata[0] !== oldest_hit.hit)
					report_mismatch("hit", int'(m_tdata[0]), int'(oldest_hit.hit));
				if (m_tdata[4:1] !== oldest_hit.hidx)
					report_mismatch("hit_index", int'(m_tdata[4:1]), int'(oldest_hit.hidx));
			end
			results_seen++;
		end
	end

	function automatic int noise16();
		return int'($urandom_range(65535));
	endfunction

	task automatic queue_word(op_t op, int idx, int px, int py, int rad,
			int cs, int sn, int scx, int scy);
		region_word_t w;
		w.op = op;
		w.idx = 4'(idx);
		w.px = 16'(px);
		w.py = 16'(py);
		w.rad = 15'(rad);
		w.cs = 16'(cs);
		w.sn = 16'(sn);
		w.scx = 16'(scx);
		w.scy = 16'(scy);
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic wait_idle();
		wait (pending_words.size() == 0 && !have_word && expected_hits.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_circle_count(int v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 5'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
		region_count = 5'(v);
	endtask

	task automatic queue_load();
		int px, py, rad;
		if ($urandom_range(1) == 0) begin
			px = int'($urandom_range(8192)) - 4096;
			py = int'($urandom_range(8192)) - 4096;
		end else begin
			px = noise16();
			py = noise16();
		end
		rad = ($urandom_range(99) < 70) ? int'($urandom_range(1024)) : int'($urandom_range(32767));
		queue_word(OP_LOAD, $urandom_range(15), px, py, rad, noise16(), noise16(),
			noise16(), noise16());
	endtask

	task automatic queue_xform();
		int px, py, cs, sn, scx, scy;
		if ($urandom_range(99) < 70) begin
			px = int'($urandom_range(4096)) - 2048;
			py = int'($urandom_range(4096)) - 2048;
			scx = $urandom_range(8192, 2048);
			scy = $urandom_range(8192, 2048);
		end else begin
			px = noise16();
			py = noise16();
			scx = noise16();
			scy = noise16();
		end
		if ($urandom_range(99) < 20) begin
			cs = 16384 * (int'($urandom_range(2)) - 1);
			sn = 16384 * (int'($urandom_range(2)) - 1);
		end else begin
			cs = int'($urandom_range(32768)) - 16384;
			sn = int'($urandom_range(32768)) - 16384;
		end
		queue_word(OP_XFORM, $urandom_range(15), px, py, $urandom_range(32767),
			cs, sn, scx, scy);
	endtask

	// queries mostly land near a live world circle, some on its edge
	task automatic queue_query(op_t op, int n_act);
		int i, cx, cy, lim, rad, roll;
		longint ox, oy;
		rad = ($urandom_range(99) < 60) ? int'($urandom_range(512)) : int'($urandom_range(32767));
		roll = $urandom_range(99);
		if (n_act == 0 || roll < 30) begin
			queue_word(op, $urandom_range(15), noise16(), noise16(), rad,
				noise16(), noise16(), noise16(), noise16());
		end else begin
			i = $urandom_range(n_act - 1);
			cx = world_x[i];
			cy = world_y[i];
			lim = int'(world_r[i]) + ((op == OP_CQUERY) ? rad : 0);
			if (roll < 45) begin
				// exactly on the boundary
				ox = lim;
				oy = 0;
			end else begin
				ox = longint'($urandom_range(2 * lim)) - lim;
				oy = longint'($urandom_range(2 * lim)) - lim;
			end
			queue_word(op, $urandom_range(15), clamp16(cx + ox), clamp16(cy + oy), rad,
				noise16(), noise16(), noise16(), noise16());
		end
	endtask

	initial begin
		int phase, count_val, n_act, chunks, roll;
		cur_word = '{OP_LOAD, 4'd0, 16'sd0, 16'sd0, 15'd0, 16'sd0, 16'sd0, 16'd0, 16'd0};
		for (int i = 0; i < NCIRC; i++) begin
			base_x[i] = '0;
			base_y[i] = '0;
			base_r[i] = '0;
			world_x[i] = '0;
			world_y[i] = '0;
			world_r[i] = '0;
		end
		region_count = 5'd1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		tb_live = 1'b1;

		// zero world table: a point at the origin misses, a circle touches entry zero
		queue_word(OP_PQUERY, 0, 0, 0, 0, noise16(), noise16(), noise16(), noise16());
		queue_word(OP_CQUERY, 0, 0, 0, 1, noise16(), noise16(), noise16(), noise16());
		queue_word(OP_CQUERY, 15, 0, 0, 0, noise16(), noise16(), noise16(), noise16());
		// identity transform, then strict boundary checks
		queue_word(OP_LOAD, 0, 0, 0, 16, noise16(), noise16(), noise16(), noise16());
		queue_word(OP_XFORM, 0, 0, 0, 0, 16384, 0, 4096, 4096);
		queue_word(OP_PQUERY, 0, 16, 0, 0, noise16(), noise16(), noise16(), noise16());
		queue_word(OP_PQUERY, 0, 15, 0, 0, noise16(), noise16(), noise16(), noise16());
		queue_word(OP_CQUERY, 0, 32, 0, 16, noise16(), noise16(), noise16(), noise16());
		queue_word(OP_CQUERY, 0, 31, 0, 16, noise16(), noise16(), noise16(), noise16());
		// extreme centre and radius, largest scale and rotation: everything saturates
		queue_word(OP_LOAD, 0, -32768, 32767, 32767, noise16(), noise16(), noise16(),
			noise16());
		queue_word(OP_XFORM, 0, 32767, -32768, 32767, -16384, 16384, 65535, 65535);
		queue_word(OP_CQUERY, 0, 32767, -32768, 32767, noise16(), noise16(), noise16(),
			noise16());
		// zero scale collapses the circle to a point of zero radius
		queue_word(OP_XFORM, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_word(OP_PQUERY, 0, 0, 0, 0, noise16(), noise16(), noise16(), noise16());
		// fill every base entry so that any count is safe to transform
		queue_word(OP_LOAD, 15, 32767, -32768, 0, noise16(), noise16(), noise16(), noise16());
		for (int e = 1; e < NCIRC - 1; e++)
			queue_word(OP_LOAD, e, int'($urandom_range(8192)) - 4096,
				int'($urandom_range(8192)) - 4096, $urandom_range(1024),
				noise16(), noise16(), noise16(), noise16());

		// random phases, each under its own circle count
		phase = 0;
		while (words_queued < 1750) begin
			case (phase)
				0: count_val = 16;
				1: count_val = 0;
				2: count_val = 31;
				3: count_val = 1;
				4: count_val = 17;
				default: begin
					roll = $urandom_range(99);
					if (roll < 8)
						count_val = 0;
					else if (roll < 18)
						count_val = $urandom_range(31, 17);
					else
						count_val = $urandom_range(16, 1);
				end
			endcase
			set_circle_count(count_val);
			n_act = (count_val > NCIRC) ? NCIRC : count_val;
			no_gaps = (phase == 5);
			// long receiver hold-off while the sender keeps offering
			if (phase == 2)
				hold_start = 1'b1;
			chunks = $urandom_range(6, 3);
			repeat (chunks) begin
				repeat ($urandom_range(12, 8)) begin
					roll = $urandom_range(99);
					if (roll < 18)
						queue_load();
					else if (roll < 28)
						queue_xform();
					else if (roll < 64)
						queue_query(OP_CQUERY, n_act);
					else
						queue_query(OP_PQUERY, n_act);
				end
				// let the shadow world table catch up so queries stay aimed
				if (!no_gaps && phase != 2)
					wait_idle();
			end
			phase++;
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run limit
	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
